### src/rcf_pkg.sv
// shared constants and codes for the reply chunk framer
package rcf_pkg;

    localparam int CHUNK_BYTES_DEF = 32;
    localparam int ADDR_W          = 5;
    localparam int DATA_W          = 32;

    // item action codes
    localparam logic [1:0] ACT_START  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_END    = 2'd2;

    // register indexes
    localparam logic [2:0] REG_START_MARKER   = 3'd0;
    localparam logic [2:0] REG_END_MARKER     = 3'd1;
    localparam logic [2:0] REG_REPLY_FLAG     = 3'd2;
    localparam logic [2:0] REG_FINISHED_CODE  = 3'd3;
    localparam logic [2:0] REG_CONTINUES_CODE = 3'd4;

    // register reset values
    localparam logic [7:0] RST_START_MARKER   = 8'd224;
    localparam logic [7:0] RST_END_MARKER     = 8'd238;
    localparam logic [7:0] RST_REPLY_FLAG     = 8'd128;
    localparam logic [7:0] RST_FINISHED_CODE  = 8'd1;
    localparam logic [7:0] RST_CONTINUES_CODE = 8'd2;

endpackage

### src/reply_chunk_framer.sv
// reply chunk framer: builds reply messages into fixed-size chunks and streams them out
//
// A start transaction writes the header (start marker, command with reply flag, parameter
// count) into the chunk buffer, one write per cycle. An append transaction that fits writes
// its byte and produces nothing. When the chunk is full, an append or end transaction first
// drains it: fill+1 bytes, the indicator and then the buffer bytes, one byte per cycle while
// the output is not stalled, then writes the pending byte. An end transaction then drains
// the finished chunk the same way. The buffer has one write port and one read port, its reads
// walked by a single index counter; the block takes no new transaction until the current one
// is done, but a final byte may still wait in the output register while the next is taken.
module reply_chunk_framer #(
    parameter int CHUNK_BYTES = rcf_pkg::CHUNK_BYTES_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // input items
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_action,
    input  logic [7:0]                s_command,
    input  logic [7:0]                s_param_count,
    input  logic [7:0]                s_data_byte,
    // result bytes
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [7:0]                m_out_byte,
    output logic                      m_chunk_first,
    output logic                      m_chunk_last,
    output logic                      m_run_last,
    // register port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [rcf_pkg::ADDR_W-1:0] paddr,
    input  logic [rcf_pkg::DATA_W-1:0] pwdata,
    output logic [rcf_pkg::DATA_W-1:0] prdata,
    output logic                      pready
);

    localparam int IDX_W = $clog2(CHUNK_BYTES);
    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(CHUNK_BYTES - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START2,
        ST_START3,
        ST_EMIT,
        ST_APPEND
    } state_t;

    // configuration registers
    logic [7:0] start_marker_reg;
    logic [7:0] end_marker_reg;
    logic [7:0] reply_flag_reg;
    logic [7:0] finished_code_reg;
    logic [7:0] continues_code_reg;

    // chunk buffer
    logic [7:0]       mem [CHUNK_BYTES];
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [7:0]       mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    logic [7:0]       rd_data_reg;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] fill_reg, fill_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [7:0]       cnt_reg, cnt_next;
    logic [7:0]       byte_reg, byte_next;
    logic             end_reg, end_next;
    logic             pend_reg, pend_next;
    logic [7:0]       ind_reg, ind_next;
    logic             run_reg, run_next;

    logic             m_valid_reg, m_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             first_reg, first_next;
    logic             clast_reg, clast_next;
    logic             rlast_reg, rlast_next;

    logic             in_acc;
    logic             load;
    logic             at_end;
    logic [7:0]       app_byte;
    logic [2:0]       reg_idx;

    assign s_ready       = (state_reg == ST_IDLE);
    assign in_acc        = s_valid && s_ready;
    assign load          = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    assign at_end        = (idx_reg == fill_reg);
    assign app_byte      = (s_action == rcf_pkg::ACT_APPEND) ? s_data_byte : end_marker_reg;
    assign m_valid       = m_valid_reg;
    assign m_out_byte    = out_byte_reg;
    assign m_chunk_first = first_reg;
    assign m_chunk_last  = clast_reg;
    assign m_run_last    = rlast_reg;
    assign pready        = 1'b1;
    assign reg_idx       = paddr[rcf_pkg::ADDR_W-1:2];

    // register read
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            rcf_pkg::REG_START_MARKER:   prdata[7:0] = start_marker_reg;
            rcf_pkg::REG_END_MARKER:     prdata[7:0] = end_marker_reg;
            rcf_pkg::REG_REPLY_FLAG:     prdata[7:0] = reply_flag_reg;
            rcf_pkg::REG_FINISHED_CODE:  prdata[7:0] = finished_code_reg;
            rcf_pkg::REG_CONTINUES_CODE: prdata[7:0] = continues_code_reg;
            default:                     prdata[7:0] = 8'd0;
        endcase
    end

    // register write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_marker_reg   <= rcf_pkg::RST_START_MARKER;
            end_marker_reg     <= rcf_pkg::RST_END_MARKER;
            reply_flag_reg     <= rcf_pkg::RST_REPLY_FLAG;
            finished_code_reg  <= rcf_pkg::RST_FINISHED_CODE;
            continues_code_reg <= rcf_pkg::RST_CONTINUES_CODE;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                rcf_pkg::REG_START_MARKER:   start_marker_reg   <= pwdata[7:0];
                rcf_pkg::REG_END_MARKER:     end_marker_reg     <= pwdata[7:0];
                rcf_pkg::REG_REPLY_FLAG:     reply_flag_reg     <= pwdata[7:0];
                rcf_pkg::REG_FINISHED_CODE:  finished_code_reg  <= pwdata[7:0];
                rcf_pkg::REG_CONTINUES_CODE: continues_code_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        idx_next      = idx_reg;
        cmd_next      = cmd_reg;
        cnt_next      = cnt_reg;
        byte_next     = byte_reg;
        end_next      = end_reg;
        pend_next     = pend_reg;
        ind_next      = ind_reg;
        run_next      = run_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        out_byte_next = out_byte_reg;
        first_next    = first_reg;
        clast_next    = clast_reg;
        rlast_next    = rlast_reg;
        mem_we        = 1'b0;
        mem_waddr     = IDX_W'(1);
        mem_wdata     = start_marker_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    cmd_next  = s_command;
                    cnt_next  = s_param_count;
                    byte_next = app_byte;
                    end_next  = (s_action == rcf_pkg::ACT_END);
                    idx_next  = '0;
                    priority if (s_action == rcf_pkg::ACT_START) begin
                        mem_we     = 1'b1;
                        state_next = ST_START2;
                    end else if (s_action == rcf_pkg::ACT_APPEND ||
                                 s_action == rcf_pkg::ACT_END) begin
                        if (fill_reg == LAST_POS) begin
                            // full chunk goes out first, byte is written afterwards
                            ind_next   = continues_code_reg;
                            run_next   = (s_action == rcf_pkg::ACT_APPEND);
                            pend_next  = 1'b1;
                            state_next = ST_EMIT;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = fill_reg + IDX_W'(1);
                            mem_wdata = app_byte;
                            fill_next = fill_reg + IDX_W'(1);
                            if (s_action == rcf_pkg::ACT_END) begin
                                ind_next   = finished_code_reg;
                                run_next   = 1'b1;
                                pend_next  = 1'b0;
                                state_next = ST_EMIT;
                            end
                        end
                    end else begin
                        // unused action code: no effect
                    end
                end
            end
            ST_START2: begin
                mem_we     = 1'b1;
                mem_waddr  = IDX_W'(2);
                mem_wdata  = cmd_reg | reply_flag_reg;
                state_next = ST_START3;
            end
            ST_START3: begin
                mem_we     = 1'b1;
                mem_waddr  = IDX_W'(3);
                mem_wdata  = cnt_reg;
                fill_next  = IDX_W'(3);
                state_next = ST_IDLE;
            end
            ST_EMIT: begin
                if (load) begin
                    m_valid_next  = 1'b1;
                    out_byte_next = (idx_reg == '0) ? ind_reg : rd_data_reg;
                    first_next    = (idx_reg == '0);
                    clast_next    = at_end;
                    rlast_next    = at_end && run_reg;
                    idx_next      = idx_reg + IDX_W'(1);
                    if (at_end) begin
                        fill_next  = '0;
                        state_next = pend_reg ? ST_APPEND : ST_IDLE;
                    end
                end
            end
            ST_APPEND: begin
                mem_we    = 1'b1;
                mem_wdata = byte_reg;
                fill_next = IDX_W'(1);
                pend_next = 1'b0;
                idx_next  = '0;
                if (end_reg) begin
                    ind_next   = finished_code_reg;
                    run_next   = 1'b1;
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // read one byte ahead of the output register
    assign mem_raddr = load ? (idx_reg + IDX_W'(1)) : idx_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg      <= idx_next;
        cmd_reg      <= cmd_next;
        cnt_reg      <= cnt_next;
        byte_reg     <= byte_next;
        end_reg      <= end_next;
        ind_reg      <= ind_next;
        run_reg      <= run_next;
        out_byte_reg <= out_byte_next;
        first_reg    <= first_next;
        clast_reg    <= clast_next;
        rlast_reg    <= rlast_next;
    end

endmodule

### src/rcf_checker.sv
// port-level checks for the reply chunk framer, bound to the top level
module rcf_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic [1:0]                s_action,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [7:0]                m_out_byte,
    input logic                      m_chunk_first,
    input logic                      m_chunk_last,
    input logic                      m_run_last
);

    // a stalled output transaction holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_run_last))
        else $error("stalled output transaction changed");

    // every emitted chunk holds at least two bytes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_chunk_first && m_chunk_last))
        else $error("chunk with a single byte");

    // the last byte of a run always closes a chunk
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_run_last |-> m_chunk_last)
        else $error("run ended inside a chunk");

    // a start transaction keeps the input busy while its header is written
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_action == rcf_pkg::ACT_START |=> !s_ready ##1 !s_ready)
        else $error("input ready during header write");

    // nothing is offered right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind reply_chunk_framer rcf_checker u_rcf_checker (.*);

### tb/reply_chunk_framer_checker.sv
// checker for the reply chunk framer: predicts chunk bytes and compares the result stream
module reply_chunk_framer_checker
    import rcf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [1:0]        s_action,
    input  logic [7:0]        s_command,
    input  logic [7:0]        s_param_count,
    input  logic [7:0]        s_data_byte,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [7:0]        m_out_byte,
    input  logic              m_chunk_first,
    input  logic              m_chunk_last,
    input  logic              m_run_last,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic [DATA_W-1:0] prdata,
    input  logic              pready,
    output int                fail_count,
    output int                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHUNK = CHUNK_BYTES_DEF;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       run_end;
    } chunk_beat_t;

    chunk_beat_t beats_due[$];

    logic [7:0]  frame_buf [0:CHUNK-1];
    int unsigned fill_pos;
    logic [7:0]  start_mark;
    logic [7:0]  end_mark;
    logic [7:0]  reply_mask;
    logic [7:0]  done_code;
    logic [7:0]  more_code;
    int          errors = 0;

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    function automatic logic [7:0] reg_value(input logic [2:0] idx);
        case (idx)
            REG_START_MARKER:   return start_mark;
            REG_END_MARKER:     return end_mark;
            REG_REPLY_FLAG:     return reply_mask;
            REG_FINISHED_CODE:  return done_code;
            REG_CONTINUES_CODE: return more_code;
            default:            return 8'h00;
        endcase
    endfunction

    task automatic flush_chunk(input logic [7:0] indicator);
        chunk_beat_t beat;
        if (fill_pos == 0)
            return;
        frame_buf[0] = indicator;
        for (int i = 0; i <= fill_pos && i < CHUNK; i++) begin
            beat.data    = frame_buf[i];
            beat.first   = (i == 0);
            beat.last    = (i == fill_pos) || (i == CHUNK - 1);
            beat.run_end = 1'b0;
            beats_due.push_back(beat);
        end
        fill_pos = 0;
    endtask

    task automatic add_byte(input logic [7:0] b);
        // a full chunk goes out with the continuation indicator first
        if (fill_pos >= CHUNK - 1)
            flush_chunk(more_code);
        fill_pos++;
        if (fill_pos < CHUNK)
            frame_buf[fill_pos] = b;
    endtask

    task automatic predict_item(input logic [1:0] act, input logic [7:0] cmd,
                                input logic [7:0] cnt, input logic [7:0] dat);
        int          depth_before;
        chunk_beat_t tail;
        depth_before = beats_due.size();
        case (act)
            ACT_START: begin
                // pending bytes are dropped without being sent
                frame_buf[1] = start_mark;
                frame_buf[2] = cmd | reply_mask;
                frame_buf[3] = cnt;
                fill_pos     = 3;
            end
            ACT_APPEND: add_byte(dat);
            ACT_END: begin
                add_byte(end_mark);
                flush_chunk(done_code);
            end
            default: ;
        endcase
        if (beats_due.size() > depth_before) begin
            tail = beats_due.pop_back();
            tail.run_end = 1'b1;
            beats_due.push_back(tail);
        end
    endtask

    task automatic check_beat();
        chunk_beat_t want;
        if (beats_due.size() == 0) begin
            $display("%0t: unexpected result byte: data=%02h first=%b last=%b run_last=%b",
                     $time, m_out_byte, m_chunk_first, m_chunk_last, m_run_last);
            errors++;
            return;
        end
        want = beats_due.pop_front();
        if (want.data !== m_out_byte || want.first !== m_chunk_first ||
            want.last !== m_chunk_last || want.run_end !== m_run_last) begin
            $display("%0t: result mismatch: expected data=%02h first=%b last=%b run_last=%b, %s",
                     $time, want.data, want.first, want.last, want.run_end,
                     $sformatf("actual data=%02h first=%b last=%b run_last=%b",
                               m_out_byte, m_chunk_first, m_chunk_last, m_run_last));
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            start_mark = RST_START_MARKER;
            end_mark   = RST_END_MARKER;
            reply_mask = RST_REPLY_FLAG;
            done_code  = RST_FINISHED_CODE;
            more_code  = RST_CONTINUES_CODE;
            fill_pos   = 0;
            for (int i = 0; i < CHUNK; i++)
                frame_buf[i] = 8'h00;
            beats_due.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[ADDR_W-1:2])
                        REG_START_MARKER:   start_mark = pwdata[7:0];
                        REG_END_MARKER:     end_mark   = pwdata[7:0];
                        REG_REPLY_FLAG:     reply_mask = pwdata[7:0];
                        REG_FINISHED_CODE:  done_code  = pwdata[7:0];
                        REG_CONTINUES_CODE: more_code  = pwdata[7:0];
                        default: ;
                    endcase
                end else if (prdata !== {24'h0, reg_value(paddr[ADDR_W-1:2])}) begin
                    $display("%0t: register read mismatch at %0h: expected %08h, actual %08h",
                             $time, paddr, {24'h0, reg_value(paddr[ADDR_W-1:2])}, prdata);
                    errors++;
                end
            end
            if (s_valid && s_ready)
                predict_item(s_action, s_command, s_param_count, s_data_byte);
            if (m_valid && m_ready)
                check_beat();
        end
        outstanding <= beats_due.size();
        fail_count  <= errors;
    end

endmodule

### tb/reply_chunk_framer_test.sv
// testbench top for the reply chunk framer: stimulus, register setup and verdict
module reply_chunk_framer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rcf_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int QUIET_LIMIT     = 2000;
    localparam int ITEMS_PER_PHASE = 25;
    localparam int NUM_PHASES      = 6;

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic [1:0]        s_action      = ACT_START;
    logic [7:0]        s_command     = 8'h00;
    logic [7:0]        s_param_count = 8'h00;
    logic [7:0]        s_data_byte   = 8'h00;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic [7:0]        m_out_byte;
    logic              m_chunk_first;
    logic              m_chunk_last;
    logic              m_run_last;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [ADDR_W-1:0] paddr         = '0;
    logic [DATA_W-1:0] pwdata        = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int fail_count;
    int outstanding;
    int send_idle_pct = 14;
    int recv_idle_pct = 77;
    int items_sent    = 0;
    int quiet_cycles  = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    reply_chunk_framer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_command     (s_command),
        .s_param_count (s_param_count),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_chunk_first (m_chunk_first),
        .m_chunk_last  (m_chunk_last),
        .m_run_last    (m_run_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    reply_chunk_framer_checker framer_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_command     (s_command),
        .s_param_count (s_param_count),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_chunk_first (m_chunk_first),
        .m_chunk_last  (m_chunk_last),
        .m_run_last    (m_run_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // ends the run if no transaction moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [1:0] act, input logic [7:0] cmd,
                             input logic [7:0] cnt, input logic [7:0] dat);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_command     <= cmd;
        s_param_count <= cnt;
        s_data_byte   <= dat;
        do @(posedge aclk); while (!s_ready);
        if (act != ACT_UNUSED)
            items_sent++;
    endtask

    task automatic send_random(input logic [1:0] act);
        send_item(act, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // holds the sender back until every expected byte has come out
    task automatic wait_drained(input int hold);
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (hold) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'h0, val};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic read_reg(input logic [2:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic read_all_regs();
        read_reg(REG_START_MARKER);
        read_reg(REG_END_MARKER);
        read_reg(REG_REPLY_FLAG);
        read_reg(REG_FINISHED_CODE);
        read_reg(REG_CONTINUES_CODE);
    endtask

    task automatic program_regs(input logic [7:0] sm, input logic [7:0] em,
                                input logic [7:0] rf, input logic [7:0] fc,
                                input logic [7:0] cc);
        write_reg(REG_START_MARKER, sm);
        write_reg(REG_END_MARKER, em);
        write_reg(REG_REPLY_FLAG, rf);
        write_reg(REG_FINISHED_CODE, fc);
        write_reg(REG_CONTINUES_CODE, cc);
        read_all_regs();
    endtask

    // a full reply; payload lengths are short, near the chunk boundary or longer
    task automatic send_message();
        int pick;
        int len;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            len = $urandom_range(0, 12);
        else if (pick < 8)
            len = $urandom_range(25, 33);
        else
            len = $urandom_range(34, 90);
        send_random(ACT_START);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 15) == 0)
                send_random(ACT_UNUSED);
            send_random(ACT_APPEND);
        end
        send_random(ACT_END);
    endtask

    task automatic send_noise();
        int n;
        case ($urandom_range(0, 3))
            0: begin
                n = $urandom_range(1, 6);
                repeat (n) send_random(ACT_APPEND);
            end
            1: send_random(ACT_END);
            2: send_random(ACT_UNUSED);
            default: begin
                // reply opened and never closed
                n = $urandom_range(0, 8);
                send_random(ACT_START);
                repeat (n) send_random(ACT_APPEND);
            end
        endcase
    endtask

    initial begin
        int target;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        read_all_regs();

        // directed part at reset register values
        send_item(ACT_START, 8'h00, 8'h00, 8'hff);
        send_item(ACT_APPEND, 8'hff, 8'hff, 8'h00);
        send_item(ACT_END, 8'h00, 8'h00, 8'h00);
        send_item(ACT_START, 8'hff, 8'hff, 8'h00);
        send_item(ACT_END, 8'hff, 8'hff, 8'hff);
        send_item(ACT_APPEND, 8'h00, 8'h00, 8'hff);
        send_item(ACT_END, 8'h00, 8'h00, 8'h00);
        send_item(ACT_END, 8'h55, 8'haa, 8'h55);
        send_item(ACT_START, 8'h5a, 8'ha5, 8'h00);
        send_item(ACT_APPEND, 8'h00, 8'h00, 8'h3c);
        send_item(ACT_START, 8'hc3, 8'h0f, 8'h00);
        send_item(ACT_APPEND, 8'h00, 8'h00, 8'h7e);
        send_item(ACT_END, 8'h00, 8'h00, 8'h00);
        send_item(ACT_UNUSED, 8'hff, 8'hff, 8'hff);
        send_item(ACT_START, 8'h01, 8'h02, 8'h00);
        send_item(ACT_UNUSED, 8'h00, 8'h00, 8'h00);
        send_item(ACT_APPEND, 8'h00, 8'h00, 8'h80);
        send_item(ACT_END, 8'h00, 8'h00, 8'h00);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained(16);
            if (ph < 2) begin
                send_idle_pct = 14;
                recv_idle_pct = 77;
            end else if (ph < 4) begin
                send_idle_pct = 77;
                recv_idle_pct = 14;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph)
                0: program_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
                1: program_regs(8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
                default: program_regs(8'($urandom), 8'($urandom), 8'($urandom),
                                      8'($urandom), 8'($urandom));
            endcase
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target) begin
                if ($urandom_range(0, 9) < 7)
                    send_message();
                else
                    send_noise();
                if ($urandom_range(0, 11) == 0)
                    wait_drained(0);
            end
        end

        wait_drained(40);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### filelist.f
src/rcf_pkg.sv
src/reply_chunk_framer.sv
src/rcf_checker.sv
tb/reply_chunk_framer_checker.sv
tb/reply_chunk_framer_test.sv
